>>> hw/rtl/checked_frame_receiver_macros.svh
// Assertion helpers used by the checker file.
`ifndef CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CHECKED_FRAME_RECEIVER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold across reset.
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int FRAME_BYTES   = 15;
  localparam int PAYLOAD_BYTES = 10;
  localparam int PAY_FIELDS    = 10;

  localparam int POS_W = $clog2(FRAME_BYTES + 1);

  typedef logic [POS_W-1:0] cfr_pos_t;

  localparam cfr_pos_t POS_SYNC     = cfr_pos_t'(0);
  localparam cfr_pos_t POS_ID       = cfr_pos_t'(1);
  localparam cfr_pos_t POS_LEN      = cfr_pos_t'(2);
  localparam cfr_pos_t POS_FIRST_PL = cfr_pos_t'(3);
  localparam cfr_pos_t POS_SUM_LAST = cfr_pos_t'(FRAME_BYTES - 3);
  localparam cfr_pos_t POS_CK_HI    = cfr_pos_t'(FRAME_BYTES - 2);
  localparam cfr_pos_t POS_END      = cfr_pos_t'(FRAME_BYTES);

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ACCEPT   = 2'd1,
    EV_MISMATCH = 2'd2,
    EV_TIMEOUT  = 2'd3
  } cfr_event_t;

  typedef enum logic [1:0] {
    REG_SYNC    = 2'd0,
    REG_ID      = 2'd1,
    REG_LEN     = 2'd2,
    REG_TIMEOUT = 2'd3
  } cfr_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [7:0]  sync_pattern;
    logic [7:0]  frame_id;
    logic [7:0]  length_code;
    logic [15:0] timeout_ticks;
  } cfr_cfg_t;

  localparam cfr_cfg_t CFG_RESET = '{
    sync_pattern:  8'd165,
    frame_id:      8'd0,
    length_code:   8'd10,
    timeout_ticks: 16'd100
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } cfr_item_t;

  typedef struct packed {
    cfr_event_t                 event_res;
    logic                       comm_error;
    logic [PAY_FIELDS-1:0][7:0] pay;
  } cfr_result_t;

endpackage

>>> hw/rtl/cfr_core.sv
`timescale 1ns / 1ps

module cfr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_fire,
  input  cfr_pkg::cfr_item_t  item,
  input  cfr_pkg::cfr_cfg_t   cfg,
  output cfr_pkg::cfr_result_t result
);
  import cfr_pkg::*;

  logic [7:0]  store_r [FRAME_BYTES];
  cfr_pos_t    pos_r, pos_nxt, pos_inc;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] idle_r, idle_nxt, idle_inc;
  logic        err_r, err_nxt;
  logic [PAY_FIELDS-1:0][7:0] pay_r, pay_nxt, pay_cap;
  logic [7:0]  sync_byte;
  logic [15:0] ck;
  cfr_event_t  ev;

  // Payload snapshot straight from the frame store; fields outside the
  // frame keep their latched value.
  for (genvar gi = 0; gi < PAY_FIELDS; gi++) begin : g_cap
    if (gi < PAYLOAD_BYTES && gi + 5 < FRAME_BYTES) begin : g_take
      assign pay_cap[gi] = store_r[gi + 3];
    end else begin : g_keep
      assign pay_cap[gi] = pay_r[gi];
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    idle_nxt = idle_r;
    err_nxt  = err_r;
    pay_nxt  = pay_r;
    ev       = EV_NONE;
    idle_inc = idle_r + 16'd1;
    pos_inc  = (pos_r < POS_END) ? pos_r + cfr_pos_t'(1) : pos_r;
    // sync byte as it stands after this byte is stored
    sync_byte = (pos_r == POS_SYNC) ? item.rx_byte : store_r[0];
    ck        = {store_r[POS_CK_HI], item.rx_byte};

    if (item_fire) begin
      if (item.req_type == REQ_TICK) begin
        if (idle_inc >= cfg.timeout_ticks) begin
          idle_nxt = '0;
          pos_nxt  = POS_SYNC;
          err_nxt  = 1'b1;
          ev       = EV_TIMEOUT;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        if (pos_r == POS_ID) begin
          sum_nxt = {8'd0, item.rx_byte};
        end else if (pos_r == POS_SYNC) begin
          sum_nxt = '0;
        end else if (pos_r <= POS_SUM_LAST) begin
          sum_nxt = sum_r + {8'd0, item.rx_byte};
        end

        pos_nxt = pos_inc;
        if (sync_byte != cfg.sync_pattern) begin
          pos_nxt = POS_SYNC;
        end else if (pos_inc == POS_LEN) begin
          if (item.rx_byte != cfg.frame_id) pos_nxt = POS_SYNC;
        end else if (pos_inc == POS_FIRST_PL) begin
          if (item.rx_byte != cfg.length_code) pos_nxt = POS_SYNC;
        end else if (pos_inc == POS_END) begin
          if (ck == sum_nxt) begin
            pay_nxt  = pay_cap;
            idle_nxt = '0;
            err_nxt  = 1'b0;
            ev       = EV_ACCEPT;
          end else begin
            ev = EV_MISMATCH;
          end
          pos_nxt = POS_SYNC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_SYNC;
      sum_r  <= '0;
      idle_r <= '0;
      err_r  <= 1'b0;
      pay_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      idle_r <= idle_nxt;
      err_r  <= err_nxt;
      pay_r  <= pay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.req_type == REQ_BYTE && pos_r < POS_END) begin
      store_r[pos_r] <= item.rx_byte;
    end
  end

  assign result.event_res  = ev;
  assign result.comm_error = err_nxt;
  assign result.pay        = pay_nxt;

endmodule

>>> hw/rtl/cfr_skid.sv
`timescale 1ns / 1ps

module cfr_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfr_pkg::cfr_result_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cfr_pkg::cfr_result_t out_data
);
  import cfr_pkg::*;

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  cfr_result_t main_r, main_nxt;
  cfr_result_t skid_r, skid_nxt;
  logic        in_fire, out_fire;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (out_fire || !main_valid_r) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = in_data;
        main_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      // output stalled: park the transaction in the skid stage
      skid_nxt       = in_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

>>> hw/rtl/checked_frame_receiver.sv
`timescale 1ns / 1ps
// A result is registered in the output buffer, in its skid stage if stalled.
// Throughput: one transaction per cycle unless stalled; the frame check keeps
// a running sum, so each step is one add and a few compares ahead of main_r.
// A two-entry output buffer keeps in_ready high while one result is stalled.
// Reset (rst_n low, synchronous) restores cfg defaults, clears control state.

module checked_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_res,
  output logic                          out_comm_error,
  output logic [7:0]                    out_pay0,
  output logic [7:0]                    out_pay1,
  output logic [7:0]                    out_pay2,
  output logic [7:0]                    out_pay3,
  output logic [7:0]                    out_pay4,
  output logic [7:0]                    out_pay5,
  output logic [7:0]                    out_pay6,
  output logic [7:0]                    out_pay7,
  output logic [7:0]                    out_pay8,
  output logic [7:0]                    out_pay9,
  input  logic                          cfg_we,
  input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cfr_pkg::*;

  cfr_cfg_t    cfg_r, cfg_nxt;
  cfr_item_t   item;
  cfr_result_t core_res, out_res;
  logic        in_fire;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfr_reg_t'(cfg_index))
        REG_SYNC:    cfg_nxt.sync_pattern  = cfg_wdata[7:0];
        REG_ID:      cfg_nxt.frame_id      = cfg_wdata[7:0];
        REG_LEN:     cfg_nxt.length_code   = cfg_wdata[7:0];
        REG_TIMEOUT: cfg_nxt.timeout_ticks = cfg_wdata[15:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_fire       = in_valid && in_ready;
  assign item.req_type = in_req_type;
  assign item.rx_byte  = in_rx_byte;

  cfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .item      (item),
    .cfg       (cfg_r),
    .result    (core_res)
  );

  cfr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_event_res  = out_res.event_res;
  assign out_comm_error = out_res.comm_error;
  assign out_pay0       = out_res.pay[0];
  assign out_pay1       = out_res.pay[1];
  assign out_pay2       = out_res.pay[2];
  assign out_pay3       = out_res.pay[3];
  assign out_pay4       = out_res.pay[4];
  assign out_pay5       = out_res.pay[5];
  assign out_pay6       = out_res.pay[6];
  assign out_pay7       = out_res.pay[7];
  assign out_pay8       = out_res.pay[8];
  assign out_pay9       = out_res.pay[9];

endmodule

>>> hw/rtl/cfr_checker.sv
`timescale 1ns / 1ps
`include "checked_frame_receiver_macros.svh"

module cfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic       out_comm_error,
  input logic [7:0] out_pay0,
  input logic [7:0] out_pay9
);
  import cfr_pkg::*;

  `CFR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CFR_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_event_res) && $stable(out_comm_error) && $stable(out_pay0) && $stable(out_pay9), "stalled result changed")
  `CFR_ASSERT(a_accept_clears, out_valid && out_event_res == EV_ACCEPT |-> !out_comm_error, "good frame left error set")
  `CFR_ASSERT(a_timeout_sets, out_valid && out_event_res == EV_TIMEOUT |-> out_comm_error, "timeout without error flag")
  `CFR_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind checked_frame_receiver cfr_checker u_cfr_checker (.*);
